FILE: rtl/adll_pkg.sv
// shared types, codes and defaults for the array doubly linked list
package adll_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned MAX_WALK  = 16;

  localparam logic [3:0] OP_ADD_FIRST = 4'd0;
  localparam logic [3:0] OP_ADD_AFTER = 4'd1;
  localparam logic [3:0] OP_ADD_LAST  = 4'd2;
  localparam logic [3:0] OP_DEL_FIRST = 4'd3;
  localparam logic [3:0] OP_DEL_AFTER = 4'd4;
  localparam logic [3:0] OP_DEL_LAST  = 4'd5;
  localparam logic [3:0] OP_DEL_ALL   = 4'd6;
  localparam logic [3:0] OP_WALK_FWD  = 4'd7;
  localparam logic [3:0] OP_WALK_REV  = 4'd8;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOTHING = 3'd3;
  localparam logic [2:0] ST_BADPOS  = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  position;
    logic [31:0] name_word;
    logic [31:0] date_word;
    logic [31:0] amount_word;
  } req_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] out_name;
    logic [31:0] out_date;
    logic [31:0] out_amount;
    logic [2:0]  status;
    logic [4:0]  count;
    logic        last;
  } rsp_t;

endpackage

FILE: rtl/adll_free.sv
// registered lowest free slot search
module adll_free #(
  parameter int unsigned SLOTS = adll_pkg::SLOTS_DEF,
  parameter int unsigned LW    = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [SLOTS-1:0] used,
  output logic [LW-1:0]    free
);

  logic [LW-1:0] low;

  always_comb begin
    low = LW'(SLOTS);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) low = LW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) free <= '0;
    else free <= low;
  end

endmodule

FILE: rtl/adll_mem.sv
// link and payload memories, one write and one registered read each
module adll_mem #(
  parameter int unsigned SLOTS = adll_pkg::SLOTS_DEF,
  parameter int unsigned LW    = $clog2(SLOTS + 1),
  parameter int unsigned SW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic [SW-1:0] rd_addr,
  input  logic          nw_en,
  input  logic [SW-1:0] nw_addr,
  input  logic [LW-1:0] nw_data,
  input  logic          pw_en,
  input  logic [SW-1:0] pw_addr,
  input  logic [LW-1:0] pw_data,
  input  logic          dw_en,
  input  logic [SW-1:0] dw_addr,
  input  logic [31:0]   dw_name,
  input  logic [31:0]   dw_date,
  input  logic [31:0]   dw_amount,
  output logic [LW-1:0] next_rd,
  output logic [LW-1:0] prev_rd,
  output logic [31:0]   rd_name,
  output logic [31:0]   rd_date,
  output logic [31:0]   rd_amount
);

  logic [LW-1:0] next_mem [SLOTS];
  logic [LW-1:0] prev_mem [SLOTS];
  logic [31:0]   name_mem [SLOTS];
  logic [31:0]   date_mem [SLOTS];
  logic [31:0]   amount_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (dw_en) begin
      name_mem[dw_addr]   <= dw_name;
      date_mem[dw_addr]   <= dw_date;
      amount_mem[dw_addr] <= dw_amount;
    end
    next_rd   <= next_mem[rd_addr];
    prev_rd   <= prev_mem[rd_addr];
    rd_name   <= name_mem[rd_addr];
    rd_date   <= date_mem[rd_addr];
    rd_amount <= amount_mem[rd_addr];
  end

endmodule

FILE: rtl/array_doubly_linked_list_top.sv
// array doubly linked list: sequencer, head/tail/count and used bits
// inserts and deletes read the links they need, then write them; most errors and clear all
// answer at decode; walks do one registered link read per element and wait on a busy result
// one item at a time: a new item is taken once the previous result has left
// reset empties the list at once through the used bits; links are only read
// for used slots, so the memories need no clearing pass
module array_doubly_linked_list_top #(
  parameter int unsigned SLOTS = adll_pkg::SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  adll_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output adll_pkg::rsp_t  rsp
);

  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_INS_RD = 4'd2;
  localparam logic [3:0] S_INS_A  = 4'd3;
  localparam logic [3:0] S_INS_A2 = 4'd4;
  localparam logic [3:0] S_INS_H  = 4'd5;
  localparam logic [3:0] S_INS_H2 = 4'd6;
  localparam logic [3:0] S_DL     = 4'd7;
  localparam logic [3:0] S_DH     = 4'd8;
  localparam logic [3:0] S_DA     = 4'd9;
  localparam logic [3:0] S_RA1    = 4'd10;
  localparam logic [3:0] S_RA2    = 4'd11;
  localparam logic [3:0] S_WK_ISS = 4'd12;
  localparam logic [3:0] S_WK     = 4'd13;

  logic [3:0]       state, state_next;
  adll_pkg::req_t   req_q;
  logic [SLOTS-1:0] used, used_next;
  logic [LW-1:0]    head, head_next, tail, tail_next, cnt, cnt_next;
  logic [LW-1:0]    cur, cur_next, vic, vic_next, anc, anc_next;
  logic [LW-1:0]    aft, aft_next, nsl, nsl_next;
  logic [3:0]       k, k_next;
  logic [LW-1:0]    free;

  // memory ports
  logic [LW-1:0] rd_addr;
  logic          nw_en, pw_en, dw_en;
  logic [LW-1:0] nw_addr, nw_data, pw_addr, pw_data;
  logic [LW-1:0] next_rd, prev_rd;
  logic [31:0]   rd_name, rd_date, rd_amount;

  // result under construction
  logic          emit, em_walk, em_last;
  logic [LW-1:0] em_slot;
  logic [2:0]    em_status;

  logic accept, out_free, pos_used, is_fwd, fin;
  logic [LW-1:0] pos_l, wk_start, nx;

  function automatic logic used_at(input logic [LW-1:0] l, input logic [SLOTS-1:0] u);
    logic [SW-1:0] ix;
    ix = l[SW-1:0];
    used_at = (32'(l) < SLOTS) && u[ix];
  endfunction

  adll_free #(.SLOTS(SLOTS), .LW(LW)) u_free (
    .clk(clk), .rst(rst), .used(used), .free(free)
  );

  adll_mem #(.SLOTS(SLOTS), .LW(LW), .SW(SW)) u_mem (
    .clk(clk),
    .rd_addr(rd_addr[SW-1:0]),
    .nw_en(nw_en), .nw_addr(nw_addr[SW-1:0]), .nw_data(nw_data),
    .pw_en(pw_en), .pw_addr(pw_addr[SW-1:0]), .pw_data(pw_data),
    .dw_en(dw_en), .dw_addr(nsl[SW-1:0]),
    .dw_name(req_q.name_word), .dw_date(req_q.date_word),
    .dw_amount(req_q.amount_word),
    .next_rd(next_rd), .prev_rd(prev_rd),
    .rd_name(rd_name), .rd_date(rd_date), .rd_amount(rd_amount)
  );

  // take an item only when idle and the result register is empty
  assign req_stall = !((state == S_IDLE) && !rsp_valid);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign pos_l    = LW'(req_q.position);
  assign pos_used = (32'(req_q.position) < SLOTS) && used_at(pos_l, used);
  assign is_fwd   = (req_q.op == adll_pkg::OP_WALK_FWD);
  assign wk_start = is_fwd ? head : tail;
  assign nx       = is_fwd ? next_rd : prev_rd;
  assign fin      = !used_at(nx, used) || (k == 4'(adll_pkg::MAX_WALK - 1));

  always_comb begin
    state_next = state;
    used_next  = used;
    head_next  = head;
    tail_next  = tail;
    cnt_next   = cnt;
    cur_next   = cur;
    vic_next   = vic;
    anc_next   = anc;
    aft_next   = aft;
    nsl_next   = nsl;
    k_next     = k;
    rd_addr    = cur;
    nw_en      = 1'b0;
    nw_addr    = nsl;
    nw_data    = NIL;
    pw_en      = 1'b0;
    pw_addr    = nsl;
    pw_data    = NIL;
    dw_en      = 1'b0;
    emit       = 1'b0;
    em_walk    = 1'b0;
    em_last    = 1'b1;
    em_slot    = '0;
    em_status  = adll_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_IDLE;
        case (req_q.op)
          adll_pkg::OP_ADD_FIRST, adll_pkg::OP_ADD_LAST, adll_pkg::OP_ADD_AFTER: begin
            if (free == NIL) begin
              // full check comes ahead of the anchor check
              emit      = 1'b1;
              em_status = adll_pkg::ST_FULL;
            end else if (req_q.op == adll_pkg::OP_ADD_AFTER && !pos_used) begin
              emit      = 1'b1;
              em_status = adll_pkg::ST_BADPOS;
            end else begin
              nsl_next = free;
              if (req_q.op == adll_pkg::OP_ADD_FIRST ||
                  (req_q.op == adll_pkg::OP_ADD_LAST && !used_at(head, used))) begin
                state_next = S_INS_H;
              end else begin
                anc_next   = (req_q.op == adll_pkg::OP_ADD_LAST) ? tail : pos_l;
                rd_addr    = anc_next;
                state_next = S_INS_RD;
              end
            end
          end
          adll_pkg::OP_DEL_FIRST: begin
            if (!used_at(head, used)) begin
              emit      = 1'b1;
              em_status = adll_pkg::ST_EMPTY;
            end else begin
              vic_next   = head;
              rd_addr    = head;
              state_next = S_DH;
            end
          end
          adll_pkg::OP_DEL_LAST: begin
            if (!used_at(head, used)) begin
              emit      = 1'b1;
              em_status = adll_pkg::ST_EMPTY;
            end else begin
              rd_addr    = tail;
              state_next = S_DL;
            end
          end
          adll_pkg::OP_DEL_AFTER: begin
            if (!pos_used) begin
              emit      = 1'b1;
              em_status = adll_pkg::ST_BADPOS;
            end else begin
              anc_next   = pos_l;
              rd_addr    = pos_l;
              state_next = S_DA;
            end
          end
          adll_pkg::OP_DEL_ALL: begin
            used_next = '0;
            head_next = NIL;
            tail_next = NIL;
            cnt_next  = '0;
            emit      = 1'b1;
          end
          adll_pkg::OP_WALK_FWD, adll_pkg::OP_WALK_REV: begin
            if (!used_at(wk_start, used)) begin
              emit      = 1'b1;
              em_status = adll_pkg::ST_EMPTY;
            end else begin
              cur_next   = wk_start;
              k_next     = '0;
              state_next = S_WK_ISS;
            end
          end
          default: state_next = S_IDLE;  // undefined op, no result
        endcase
      end
      S_INS_RD: begin
        aft_next   = next_rd;
        state_next = S_INS_A;
      end
      S_INS_A: begin
        nw_en           = 1'b1;
        nw_data         = aft;
        pw_en           = 1'b1;
        pw_data         = anc;
        dw_en           = 1'b1;
        used_next[nsl[SW-1:0]] = 1'b1;
        state_next      = S_INS_A2;
      end
      S_INS_A2: begin
        nw_en   = 1'b1;
        nw_addr = anc;
        nw_data = nsl;
        if (used_at(aft, used)) begin
          pw_en   = 1'b1;
          pw_addr = aft;
          pw_data = nsl;
        end else begin
          tail_next = nsl;
        end
        cnt_next   = cnt + 1'b1;
        emit       = 1'b1;
        em_slot    = nsl;
        state_next = S_IDLE;
      end
      S_INS_H: begin
        nw_en           = 1'b1;
        nw_data         = head;
        pw_en           = 1'b1;
        pw_data         = NIL;
        dw_en           = 1'b1;
        used_next[nsl[SW-1:0]] = 1'b1;
        aft_next        = head;
        head_next       = nsl;
        if (!used_at(head, used)) tail_next = nsl;
        state_next = S_INS_H2;
      end
      S_INS_H2: begin
        if (used_at(aft, used)) begin
          pw_en   = 1'b1;
          pw_addr = aft;
          pw_data = nsl;
        end
        cnt_next   = cnt + 1'b1;
        emit       = 1'b1;
        em_slot    = nsl;
        state_next = S_IDLE;
      end
      S_DL: begin
        // single element left behind the tail means a head removal
        if (!used_at(prev_rd, used)) begin
          vic_next   = head;
          rd_addr    = head;
          state_next = S_DH;
        end else begin
          anc_next   = prev_rd;
          rd_addr    = prev_rd;
          state_next = S_RA1;
        end
      end
      S_DH: begin
        if (used_at(next_rd, used)) begin
          head_next = next_rd;
          pw_en     = 1'b1;
          pw_addr   = next_rd;
          pw_data   = NIL;
        end else begin
          head_next = NIL;
          tail_next = NIL;
        end
        used_next[vic[SW-1:0]] = 1'b0;
        cnt_next   = cnt - 1'b1;
        emit       = 1'b1;
        em_slot    = vic;
        state_next = S_IDLE;
      end
      S_DA: begin
        if (!used_at(next_rd, used)) begin
          emit       = 1'b1;
          em_status  = adll_pkg::ST_NOTHING;
          state_next = S_IDLE;
        end else begin
          vic_next   = next_rd;
          rd_addr    = next_rd;
          state_next = S_RA2;
        end
      end
      S_RA1: begin
        vic_next   = next_rd;
        rd_addr    = next_rd;
        state_next = S_RA2;
      end
      S_RA2: begin
        nw_en   = 1'b1;
        nw_addr = anc;
        nw_data = next_rd;
        if (used_at(next_rd, used)) begin
          pw_en   = 1'b1;
          pw_addr = next_rd;
          pw_data = anc;
        end else begin
          tail_next = anc;
        end
        used_next[vic[SW-1:0]] = 1'b0;
        cnt_next   = cnt - 1'b1;
        emit       = 1'b1;
        em_slot    = vic;
        state_next = S_IDLE;
      end
      S_WK_ISS: begin
        state_next = S_WK;
      end
      S_WK: begin
        // read data holds while the result register is busy
        if (out_free) begin
          emit       = 1'b1;
          em_walk    = 1'b1;
          em_last    = fin;
          em_slot    = cur;
          cur_next   = nx;
          k_next     = k + 1'b1;
          state_next = fin ? S_IDLE : S_WK_ISS;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      head      <= NIL;
      tail      <= NIL;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      head  <= head_next;
      tail  <= tail_next;
      cnt   <= cnt_next;
      if (emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    cur <= cur_next;
    vic <= vic_next;
    anc <= anc_next;
    aft <= aft_next;
    nsl <= nsl_next;
    k   <= k_next;
    if (emit) begin
      rsp.slot       <= 4'(em_slot);
      rsp.out_name   <= em_walk ? rd_name : 32'd0;
      rsp.out_date   <= em_walk ? rd_date : 32'd0;
      rsp.out_amount <= em_walk ? rd_amount : 32'd0;
      rsp.status     <= em_status;
      rsp.count      <= 5'(cnt_next);
      rsp.last       <= em_last;
    end
  end

endmodule

FILE: tb/tb_array_doubly_linked_list_top.sv
// testbench for the array doubly linked list: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_array_doubly_linked_list_top;

  localparam int unsigned NSLOT      = adll_pkg::SLOTS_DEF;
  localparam int unsigned NIL        = NSLOT;
  localparam int unsigned WATCH_MAX  = 20000;
  localparam int unsigned DRAIN_WAIT = 40;

  // list predictor and the queue of expected results
  class list_board;
    int unsigned    fwd[NSLOT];
    int unsigned    bwd[NSLOT];
    bit             busy[NSLOT];
    logic [31:0]    nm[NSLOT];
    logic [31:0]    dt[NSLOT];
    logic [31:0]    am[NSLOT];
    int unsigned    first_s;
    int unsigned    last_s;
    int unsigned    len;
    adll_pkg::rsp_t pending[$];
    int             errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < NSLOT; i++) begin
        fwd[i] = NIL;
        bwd[i] = NIL;
        busy[i] = 0;
      end
      first_s = NIL;
      last_s = NIL;
      len = 0;
    endfunction

    function bit live(int unsigned s);
      return s < NSLOT && busy[s];
    endfunction

    function int unsigned free_slot();
      for (int i = 0; i < NSLOT; i++)
        if (!busy[i]) return i;
      return NIL;
    endfunction

    function void push(int unsigned s, logic [31:0] n, logic [31:0] d, logic [31:0] a,
                       logic [2:0] st, bit fin);
      adll_pkg::rsp_t r;
      r.slot = s[3:0];
      r.out_name = n;
      r.out_date = d;
      r.out_amount = a;
      r.status = st;
      r.count = len[4:0];
      r.last = fin;
      pending.push_back(r);
    endfunction

    function void release_slot(int unsigned s);
      busy[s] = 0;
      fwd[s] = NIL;
      bwd[s] = NIL;
      if (len > 0) len--;
    endfunction

    function int unsigned link_in(int unsigned anchor, adll_pkg::req_t q);
      int unsigned n, nx;
      n = free_slot();
      busy[n] = 1;
      nm[n] = q.name_word;
      dt[n] = q.date_word;
      am[n] = q.amount_word;
      if (anchor >= NSLOT) begin
        bwd[n] = NIL;
        fwd[n] = first_s;
        if (live(first_s)) bwd[first_s] = n;
        else last_s = n;
        first_s = n;
      end else begin
        nx = fwd[anchor];
        bwd[n] = anchor;
        fwd[n] = nx;
        fwd[anchor] = n;
        if (live(nx)) bwd[nx] = n;
        else last_s = n;
      end
      len++;
      return n;
    endfunction

    function int unsigned unlink_first();
      int unsigned h, nx;
      h = first_s;
      nx = fwd[h];
      if (live(nx)) begin
        first_s = nx;
        bwd[nx] = NIL;
      end else begin
        first_s = NIL;
        last_s = NIL;
      end
      release_slot(h);
      return h;
    endfunction

    function int unsigned unlink_after(int unsigned anchor);
      int unsigned v, nx;
      v = fwd[anchor];
      nx = fwd[v];
      fwd[anchor] = nx;
      if (live(nx)) bwd[nx] = anchor;
      else last_s = anchor;
      release_slot(v);
      return v;
    endfunction

    // note an accepted item and queue what it should produce
    function void note_req(adll_pkg::req_t q);
      int unsigned s, cur, nx, k;
      bit          empty;
      bit          fwd_walk;
      empty = !live(first_s);
      fwd_walk = (q.op == adll_pkg::OP_WALK_FWD);
      case (q.op)
        adll_pkg::OP_ADD_FIRST, adll_pkg::OP_ADD_LAST, adll_pkg::OP_ADD_AFTER: begin
          if (free_slot() >= NSLOT) push(0, 0, 0, 0, adll_pkg::ST_FULL, 1);
          else if (q.op == adll_pkg::OP_ADD_AFTER && !live(q.position))
            push(0, 0, 0, 0, adll_pkg::ST_BADPOS, 1);
          else begin
            if (q.op == adll_pkg::OP_ADD_AFTER) s = link_in(q.position, q);
            else s = link_in((q.op == adll_pkg::OP_ADD_FIRST || empty) ? NIL : last_s, q);
            push(s, 0, 0, 0, adll_pkg::ST_OK, 1);
          end
        end
        adll_pkg::OP_DEL_FIRST, adll_pkg::OP_DEL_LAST: begin
          if (empty) push(0, 0, 0, 0, adll_pkg::ST_EMPTY, 1);
          else begin
            if (q.op == adll_pkg::OP_DEL_FIRST || !live(bwd[last_s])) s = unlink_first();
            else s = unlink_after(bwd[last_s]);
            push(s, 0, 0, 0, adll_pkg::ST_OK, 1);
          end
        end
        adll_pkg::OP_DEL_AFTER: begin
          if (!live(q.position)) push(0, 0, 0, 0, adll_pkg::ST_BADPOS, 1);
          else if (!live(fwd[q.position])) push(0, 0, 0, 0, adll_pkg::ST_NOTHING, 1);
          else begin
            s = unlink_after(q.position);
            push(s, 0, 0, 0, adll_pkg::ST_OK, 1);
          end
        end
        adll_pkg::OP_DEL_ALL: begin
          wipe();
          push(0, 0, 0, 0, adll_pkg::ST_OK, 1);
        end
        adll_pkg::OP_WALK_FWD, adll_pkg::OP_WALK_REV: begin
          cur = fwd_walk ? first_s : last_s;
          if (!live(cur)) push(0, 0, 0, 0, adll_pkg::ST_EMPTY, 1);
          k = 0;
          while (live(cur) && k < adll_pkg::MAX_WALK) begin
            nx = fwd_walk ? fwd[cur] : bwd[cur];
            push(cur, nm[cur], dt[cur], am[cur], adll_pkg::ST_OK,
                 !live(nx) || k == adll_pkg::MAX_WALK - 1);
            k++;
            cur = nx;
          end
        end
        default: ;
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_rsp(adll_pkg::rsp_t got);
      adll_pkg::rsp_t w;
      if (pending.size() == 0) begin
        $error("unexpected result slot=%0d status=%0d", got.slot, got.status);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.slot !== w.slot) begin
        $error("slot: expected %0d, got %0d", w.slot, got.slot); errors++;
      end
      if (got.out_name !== w.out_name) begin
        $error("out_name: expected %h, got %h", w.out_name, got.out_name); errors++;
      end
      if (got.out_date !== w.out_date) begin
        $error("out_date: expected %h, got %h", w.out_date, got.out_date); errors++;
      end
      if (got.out_amount !== w.out_amount) begin
        $error("out_amount: expected %h, got %h", w.out_amount, got.out_amount); errors++;
      end
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status); errors++;
      end
      if (got.count !== w.count) begin
        $error("count: expected %0d, got %0d", w.count, got.count); errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic           clk = 0;
  logic           rst = 1;
  logic           req_valid = 0;
  logic           req_stall;
  adll_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 0;
  adll_pkg::rsp_t rsp;

  list_board   board = new();
  int unsigned send_idle_pct = 0;  // chance of a gap before each item
  int unsigned recv_stall_pct = 0; // chance of stalling the result side per cycle
  int unsigned quiet_cycles = 0;
  bit          done = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  array_doubly_linked_list_top u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // result side: random stall, check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) board.check_rsp(rsp);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_MAX && !done) begin
      $display("array_doubly_linked_list_top regression: fail");
      $finish;
    end
  end

  // present one item and hold it until taken; valid drops only in gaps and while draining
  task automatic send_item(adll_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req <= q;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    board.note_req(q);
  endtask

  task automatic send_op(logic [3:0] op, logic [3:0] pos);
    adll_pkg::req_t q;
    q.op = op;
    q.position = pos;
    q.name_word = $urandom;
    q.date_word = $urandom;
    q.amount_word = $urandom;
    send_item(q);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain();
    req_valid <= 0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  // random item mostly aimed at used slots so anchors are valid
  task automatic send_random();
    adll_pkg::req_t q;
    int unsigned    pick;
    pick = $urandom_range(99);
    q.name_word = $urandom;
    q.date_word = $urandom;
    q.amount_word = $urandom;
    q.position = 4'($urandom_range(15));
    if (pick < 4) q.op = 4'($urandom_range(15, 9));     // undefined op, no result
    else if (pick < 6) q.op = adll_pkg::OP_DEL_ALL;
    else if (pick < 14) q.op = $urandom_range(1) ? adll_pkg::OP_WALK_FWD : adll_pkg::OP_WALK_REV;
    else if (pick < 62) q.op = 4'($urandom_range(2));   // inserts dominate to fill the pool
    else q.op = 4'($urandom_range(5, 3));
    // steer anchors onto live slots most of the time
    if ((q.op == adll_pkg::OP_ADD_AFTER || q.op == adll_pkg::OP_DEL_AFTER) && board.len > 0
        && $urandom_range(99) < 80) begin
      do q.position = 4'($urandom_range(15)); while (!board.busy[q.position]);
    end
    send_item(q);
  endtask

  initial begin
    adll_pkg::req_t q;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty list cases
    send_op(adll_pkg::OP_DEL_FIRST, 0);
    send_op(adll_pkg::OP_DEL_LAST, 0);
    send_op(adll_pkg::OP_WALK_FWD, 0);
    send_op(adll_pkg::OP_WALK_REV, 0);
    send_op(adll_pkg::OP_DEL_AFTER, 0);
    send_op(adll_pkg::OP_ADD_AFTER, 15);
    send_op(adll_pkg::OP_ADD_LAST, 0);           // add_last on empty acts as add_first
    // field extremes on the payload
    q = '{op: adll_pkg::OP_ADD_FIRST, position: 4'hF,
          name_word: '1, date_word: '1, amount_word: '1};
    send_item(q);
    q = '{op: adll_pkg::OP_ADD_AFTER, position: 4'h0,
          name_word: '0, date_word: '0, amount_word: '0};
    send_item(q);
    send_op(adll_pkg::OP_DEL_AFTER, 4'h2);       // anchor is tail
    send_op(adll_pkg::OP_DEL_AFTER, 4'h1);
    send_op(adll_pkg::OP_WALK_FWD, 0);
    send_op(4'd15, 0);                           // undefined op
    // fill the pool past full, then walk the full length both ways
    repeat (15) send_op(adll_pkg::OP_ADD_LAST, 0);
    send_op(adll_pkg::OP_ADD_AFTER, 4'h3);
    send_op(adll_pkg::OP_WALK_FWD, 0);
    send_op(adll_pkg::OP_WALK_REV, 0);
    send_op(adll_pkg::OP_DEL_LAST, 0);
    send_op(adll_pkg::OP_DEL_FIRST, 0);
    send_op(adll_pkg::OP_DEL_ALL, 0);
    drain();

    // random phases with varying idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (57) send_random();
      if (ph == 1) drain();
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    done = 1;
    if (board.errors == 0 && board.pending.size() == 0)
      $display("array_doubly_linked_list_top regression: pass");
    else
      $display("array_doubly_linked_list_top regression: fail");
    $finish;
  end
endmodule
